### rtl/ptt_pkg.sv
// Shared types and codes for the periodic task table.
// No dependencies; every other file imports this package.
`default_nettype none

package ptt_pkg;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_STOP  = 2'd1;
    localparam logic [1:0] ACT_RUN   = 2'd2;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_IGNORED = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] period;
        logic [7:0]  task_id;
        logic [31:0] now;
    } req_word_t;

    typedef struct packed {
        logic [3:0] task_index;
        logic       fired;
        logic [1:0] status;
        logic       last;
    } rsp_word_t;

    typedef struct packed {
        logic accept;
        logic issue;
        logic finish;
    } ptt_cmd_t;

    typedef struct packed {
        logic out_free;
        logic all_issued;
        logic chk_busy;
        logic stall;
    } ptt_stat_t;

endpackage

`default_nettype wire

### rtl/ptt_req_if.sv
// Request channel carrying one input word with a valid/ready handshake.
// Depends on ptt_pkg for the word type.
`default_nettype none

interface ptt_req_if;
    import ptt_pkg::*;

    logic      valid;
    logic      ready;
    req_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/ptt_rsp_if.sv
// Response channel carrying one result word with a valid/ready handshake.
// Depends on ptt_pkg for the word type.
`default_nettype none

interface ptt_rsp_if;
    import ptt_pkg::*;

    logic      valid;
    logic      ready;
    rsp_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/ptt_ctrl.sv
// Sequencing state machine of the periodic task table.
// Depends on ptt_pkg; drives the datapath through command and status structs.
`default_nettype none

module ptt_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    input  wire logic [1:0]         req_action,
    input  wire ptt_pkg::ptt_stat_t st,
    output ptt_pkg::ptt_cmd_t       cmd,
    output logic                    req_ready
);
    import ptt_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready  = st.out_free;
                cmd.accept = req_valid && st.out_free;
                if (cmd.accept && (req_action == ACT_RUN))
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.issue = !st.stall && !st.all_issued;
                if (st.all_issued && !st.chk_busy)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.finish = st.out_free;
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.issue, cmd.finish}))
        else $error("More than one datapath command in a cycle.");

    a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) |-> (st.all_issued && !st.chk_busy))
        else $error("Scan finished with entries still in flight.");

    a_scan_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && req_action == ACT_RUN) |=> (state_reg == S_SCAN))
        else $error("Run word did not start a scan.");

endmodule

`default_nettype wire

### rtl/ptt_dp.sv
// Datapath of the periodic task table: task memories, valid bits, scan
// check stage, pending result and output register. Depends on ptt_pkg.
`default_nettype none

module ptt_dp
#(
    parameter int MAX_TASKS = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ptt_pkg::ptt_cmd_t  cmd,
    output ptt_pkg::ptt_stat_t      st,
    input  wire ptt_pkg::req_word_t req_data,
    input  wire logic               rsp_ready,
    output logic                    rsp_valid,
    output ptt_pkg::rsp_word_t      rsp_data
);
    import ptt_pkg::*;

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

    function automatic logic [3:0] low4(input logic [IDX_W-1:0] v);
        logic [IDX_W+3:0] w;
        w = {4'b0000, v};
        return w[3:0];
    endfunction

    logic [15:0] period_mem [MAX_TASKS];
    logic [31:0] last_mem [MAX_TASKS];

    logic [CNT_W-1:0]     task_count_reg, task_count_next;
    logic [MAX_TASKS-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]     scan_addr_reg, scan_addr_next;
    logic                 chk_valid_reg, chk_valid_next;
    logic                 pend_full_reg, pend_full_next;
    logic                 out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]     chk_addr_reg;
    logic [IDX_W-1:0]     pend_idx_reg;
    logic [15:0]          period_rd_reg;
    logic [31:0]          last_rd_reg;
    logic [31:0]          now_reg;
    rsp_word_t            out_data_reg, out_data_next;

    logic             out_free;
    logic             hit;
    logic             stall;
    logic             take;
    logic             out_load;
    logic             can_start;
    logic             stop_ok;
    logic             start_wr;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] id_idx;
    logic [IDX_W-1:0] scan_idx;
    logic [31:0]      due;

    assign out_free  = !out_valid_reg || rsp_ready;
    assign slot      = task_count_reg[IDX_W-1:0];
    assign id_idx    = req_data.task_id[IDX_W-1:0];
    assign scan_idx  = scan_addr_reg[IDX_W-1:0];
    assign can_start = task_count_reg < CNT_W'(MAX_TASKS);
    assign stop_ok   = (CMP_W'(req_data.task_id) < CMP_W'(task_count_reg)) && valid_reg[id_idx];
    assign start_wr  = cmd.accept && (req_data.action == ACT_START) && can_start;
    assign due       = {16'h0000, period_rd_reg} + last_rd_reg;
    assign hit       = chk_valid_reg && (due <= now_reg);
    assign stall     = hit && pend_full_reg && !out_free;
    assign take      = hit && !stall;

    assign st.out_free   = out_free;
    assign st.all_issued = (scan_addr_reg == task_count_reg);
    assign st.chk_busy   = chk_valid_reg;
    assign st.stall      = stall;

    always_comb
    begin
        task_count_next = task_count_reg;
        valid_next      = valid_reg;
        scan_addr_next  = scan_addr_reg;
        chk_valid_next  = chk_valid_reg;
        pend_full_next  = pend_full_reg;
        out_load        = 1'b0;
        out_data_next   = out_data_reg;

        if (cmd.accept)
        begin
            out_load      = 1'b1;
            out_data_next = '{task_index: 4'h0, fired: 1'b0, status: STAT_DONE, last: 1'b1};
            case (req_data.action)
                ACT_START:
                begin
                    if (can_start)
                    begin
                        valid_next[slot]         = 1'b1;
                        task_count_next          = task_count_reg + 1'b1;
                        out_data_next.task_index = low4(slot);
                    end
                    else
                    begin
                        out_data_next.status = STAT_FULL;
                    end
                end
                ACT_STOP:
                begin
                    if (stop_ok)
                    begin
                        valid_next[id_idx] = 1'b0;
                    end
                    else
                    begin
                        out_data_next.status = STAT_IGNORED;
                    end
                end
                ACT_RUN:
                begin
                    out_load       = 1'b0;
                    scan_addr_next = '0;
                    pend_full_next = 1'b0;
                end
                default:
                begin
                    out_load = 1'b1;
                end
            endcase
        end

        if (!stall)
        begin
            chk_valid_next = cmd.issue && valid_reg[scan_idx];
        end
        if (cmd.issue)
        begin
            scan_addr_next = scan_addr_reg + 1'b1;
        end

        if (take)
        begin
            pend_full_next = 1'b1;
            if (pend_full_reg)
            begin
                out_load      = 1'b1;
                out_data_next = '{task_index: low4(pend_idx_reg), fired: 1'b1,
                                  status: STAT_DONE, last: 1'b0};
            end
        end

        if (cmd.finish)
        begin
            out_load       = 1'b1;
            pend_full_next = 1'b0;
            out_data_next  = '{task_index: pend_full_reg ? low4(pend_idx_reg) : 4'h0,
                               fired: pend_full_reg, status: STAT_DONE, last: 1'b1};
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg <= '0;
            valid_reg      <= '0;
            scan_addr_reg  <= '0;
            chk_valid_reg  <= 1'b0;
            pend_full_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            task_count_reg <= task_count_next;
            valid_reg      <= valid_next;
            scan_addr_reg  <= scan_addr_next;
            chk_valid_reg  <= chk_valid_next;
            pend_full_reg  <= pend_full_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (cmd.accept && (req_data.action == ACT_RUN))
        begin
            now_reg <= req_data.now;
        end
        if (take)
        begin
            pend_idx_reg <= chk_addr_reg;
        end
        if (cmd.issue)
        begin
            chk_addr_reg <= scan_idx;
        end
    end

    // Task memories: one write port shared by start and due updates, one
    // registered read port driven by the scan address.
    always_ff @(posedge clk)
    begin
        if (start_wr)
        begin
            period_mem[slot] <= req_data.period;
        end
        if (start_wr)
        begin
            last_mem[slot] <= 32'h0000_0000;
        end
        else if (take)
        begin
            last_mem[chk_addr_reg] <= now_reg;
        end
        if (cmd.issue)
        begin
            period_rd_reg <= period_mem[scan_idx];
            last_rd_reg   <= last_mem[scan_idx];
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        task_count_reg <= CNT_W'(MAX_TASKS))
        else $error("Task count beyond table size.");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        stall |-> (pend_full_reg && out_valid_reg && !rsp_ready))
        else $error("Scan stalled without a blocked result.");

    a_chk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        chk_valid_reg |-> (CNT_W'(chk_addr_reg) < task_count_reg))
        else $error("Checked entry lies beyond the task count.");

    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp_ready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("Waiting result word was overwritten.");

endmodule

`default_nettype wire

### rtl/periodic_task_table.sv
// Periodic task table: start, stop and run words, one result word per start,
// stop or unused action, one per due task (or one if none is due) on a run.
// Start and stop results appear in the cycle after acceptance. A run
// scans every slot below the task count, stopped ones too, one per cycle
// from the task memories, then releases the final result; it slows only
// while the output is held. Outside a run, the next word is accepted once
// the output is free. Reset clears valid bits and task count, not memories.
`default_nettype none

module periodic_task_table
#(
    parameter int MAX_TASKS = 16
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    ptt_req_if.sink    req,
    ptt_rsp_if.source  rsp
);
    import ptt_pkg::*;

    ptt_cmd_t  cmd;
    ptt_stat_t st;
    logic      req_ready;
    logic      rsp_valid;
    rsp_word_t rsp_data;

    ptt_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_action (req.data.action),
        .st         (st),
        .cmd        (cmd),
        .req_ready  (req_ready)
    );

    ptt_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .req_data  (req.data),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data)
    );

    assign req.ready = req_ready;
    assign rsp.valid = rsp_valid;
    assign rsp.data  = rsp_data;

endmodule

`default_nettype wire
